@@ src/fspm_pkg.sv @@
// Shared types, constants and register codes for the fader smoothing and pitch map unit.
package fspm_pkg;

  localparam int unsigned SAMPLE_BITS       = 12;
  localparam int unsigned FRACTION_BITS_DEF = 4;
  localparam int unsigned MAP_BITS          = 14;
  localparam int unsigned SHIFT_BITS        = 4;
  localparam int unsigned WINDOW_BITS       = 10;
  localparam int unsigned COUNT_BITS        = 8;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS     = SAMPLE_BITS;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [MAP_BITS-1:0]    MAP_ZERO = '0;
  localparam logic [MAP_BITS-1:0]    MAP_MID  = MAP_BITS'(8192);
  localparam logic [MAP_BITS-1:0]    MAP_TOP  = MAP_BITS'(16383);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  localparam logic [SAMPLE_BITS-1:0] SNAP_RST     = SAMPLE_BITS'(64);
  localparam logic [SHIFT_BITS-1:0]  SHIFT_RST    = SHIFT_BITS'(3);
  localparam logic [SAMPLE_BITS-1:0] LOW_RST      = SAMPLE_BITS'(64);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST     = SAMPLE_BITS'(4031);
  localparam logic [SAMPLE_BITS-1:0] DETENT_RST   = SAMPLE_BITS'(2048);
  localparam logic [WINDOW_BITS-1:0] WINDOW_RST   = WINDOW_BITS'(32);
  localparam logic [COUNT_BITS-1:0]  INTERVAL_RST = COUNT_BITS'(10);

  typedef enum logic [1:0] {
    OP_SEED   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_STORE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SNAP     = 3'd0,
    CFG_SHIFT    = 3'd1,
    CFG_LOW      = 3'd2,
    CFG_HIGH     = 3'd3,
    CFG_DETENT   = 3'd4,
    CFG_WINDOW   = 3'd5,
    CFG_INTERVAL = 3'd6,
    CFG_SPARE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] snap_threshold;
    logic [SHIFT_BITS-1:0]  smoothing_shift;
    logic [SAMPLE_BITS-1:0] low_limit;
    logic [SAMPLE_BITS-1:0] high_limit;
    logic [SAMPLE_BITS-1:0] detent_point;
    logic [WINDOW_BITS-1:0] detent_window;
    logic [COUNT_BITS-1:0]  tap_interval;
  } cfg_t;

  typedef struct packed {
    op_e_t                  kind;
    logic [SAMPLE_BITS-1:0] reading;
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic [MAP_BITS-1:0]    mapped_value;
    logic [SAMPLE_BITS-1:0] lowest_seen;
    logic [SAMPLE_BITS-1:0] highest_seen;
    logic [SAMPLE_BITS-1:0] tap_value;
    logic                   tap_due;
  } res_t;

endpackage

@@ src/fspm_front.sv @@
// Front end: accepts input words, classifies the operation and queues them for the back end.
module fspm_front import fspm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_operation,
  input  logic [SAMPLE_BITS-1:0] in_reading,
  output logic                   q_valid,
  output cmd_t                   q_cmd,
  input  logic                   q_pop
);

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                push_ok;
  logic                pop_ok;
  cmd_t                cmd_in;

  assign in_full = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  // classify: operation code becomes the command kind
  assign cmd_in.kind    = op_e_t'(in_operation);
  assign cmd_in.reading = in_reading;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/fspm_back.sv @@
// Back end: filter, tracking, tap counter, two-segment map with serial divider, result register.
module fspm_back import fspm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  input  logic res_pop,
  output logic res_valid,
  output res_t res
);

  localparam int unsigned ACC_BITS  = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned DIV_STEPS = MAP_BITS - 1;
  localparam int unsigned STEP_BITS = $clog2(DIV_STEPS);
  localparam int unsigned NUM_BITS  = SAMPLE_BITS + DIV_STEPS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r;
  logic [ACC_BITS-1:0]     acc_r;
  logic [SAMPLE_BITS-1:0]  cur_r, min_r, max_r, tap_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic                    due_r;
  logic                    track_r;
  logic [SAMPLE_BITS-1:0]  rem_r, div_r;
  logic [DIV_STEPS-1:0]    quo_r;
  logic                    upper_r;
  logic [STEP_BITS-1:0]    step_r;
  logic [MAP_BITS-1:0]     map_r;
  logic                    res_valid_r;
  res_t                    res_r;

  // filter datapath
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    tap_hit;
  logic [SAMPLE_BITS-1:0]  delta_mag;
  logic                    snap;
  logic [ACC_BITS-1:0]     target;
  logic signed [ACC_BITS:0] err, step;
  logic [ACC_BITS-1:0]     acc_new;

  // map classification
  logic                    lo_hit, hi_hit, below, in_win;
  logic [SAMPLE_BITS-1:0]  off_abs, d_lo, d_hi, div_lo, div_hi;
  logic [NUM_BITS-1:0]     num_hi;

  // divider step
  logic [SAMPLE_BITS:0]    rem_sh, rem_diff;
  logic                    ge;
  logic [DIV_STEPS-1:0]    quo_nxt;
  logic                    res_load;

  assign cnt_inc   = cnt_r + 1'b1;
  assign tap_hit   = (cnt_inc >= cfg.tap_interval);
  assign delta_mag = (cmd_r.reading >= cur_r) ? (cmd_r.reading - cur_r)
                                              : (cur_r - cmd_r.reading);
  assign snap      = (delta_mag >= cfg.snap_threshold);
  assign target    = ACC_BITS'(cmd_r.reading) << FRACTION_BITS;
  assign err       = $signed({1'b0, target}) - $signed({1'b0, acc_r});
  // arithmetic shift gives floor rounding of negative errors
  assign step      = err >>> cfg.smoothing_shift;
  assign acc_new   = snap ? target : (acc_r + step[ACC_BITS-1:0]);

  assign lo_hit  = (cur_r <= cfg.low_limit);
  assign hi_hit  = (cur_r >= cfg.high_limit);
  assign below   = (cur_r < cfg.detent_point);
  assign off_abs = below ? (cfg.detent_point - cur_r) : (cur_r - cfg.detent_point);
  assign in_win  = (off_abs <= SAMPLE_BITS'(cfg.detent_window));
  assign d_lo    = cur_r - cfg.low_limit;
  assign d_hi    = cur_r - cfg.detent_point;
  assign div_lo  = cfg.detent_point - cfg.low_limit;
  assign div_hi  = cfg.high_limit - cfg.detent_point;
  // upper segment numerator: d * (MAP_TOP - MAP_MID) = (d << 13) - d
  assign num_hi  = (NUM_BITS'(d_hi) << DIV_STEPS) - NUM_BITS'(d_hi);

  assign rem_sh   = {rem_r, quo_r[DIV_STEPS-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign quo_nxt  = {quo_r[DIV_STEPS-2:0], ge};

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign res_load  = (state_r == ST_DONE) && (!res_valid_r || res_pop);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC:  state_nxt = ST_SETUP;
      ST_SETUP: if (lo_hit || hi_hit || in_win) begin
        state_nxt = ST_DONE;
      end else begin
        state_nxt = ST_DIV;
      end
      ST_DIV:   if (step_r == STEP_BITS'(DIV_STEPS - 1)) begin
        state_nxt = ST_DONE;
      end
      ST_DONE:  if (res_load) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      cur_r       <= '0;
      min_r       <= SAMPLE_MAX;
      max_r       <= '0;
      tap_r       <= '0;
      cnt_r       <= '0;
      due_r       <= 1'b0;
      track_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        due_r   <= 1'b0;
        track_r <= 1'b0;
        unique case (cmd_r.kind)
          OP_SEED: begin
            cur_r <= cmd_r.reading;
            acc_r <= target;
            min_r <= cmd_r.reading;
            max_r <= cmd_r.reading;
            cnt_r <= '0;
          end
          OP_UPDATE: begin
            cnt_r   <= tap_hit ? '0 : cnt_inc;
            due_r   <= tap_hit;
            track_r <= 1'b1;
            acc_r   <= acc_new;
            cur_r   <= acc_new[ACC_BITS-1:FRACTION_BITS];
          end
          OP_STORE: tap_r <= cmd_r.reading;
          OP_NONE:  ;
          default:  ;
        endcase
      end
      // min and max follow the new filtered value in the next cycle
      if ((state_r == ST_SETUP) && track_r) begin
        if (cur_r < min_r) begin
          min_r <= cur_r;
        end
        if (cur_r > max_r) begin
          max_r <= cur_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == ST_SETUP) begin
      step_r <= '0;
      priority if (lo_hit) begin
        map_r <= MAP_ZERO;
      end else if (hi_hit) begin
        map_r <= MAP_TOP;
      end else if (in_win) begin
        map_r <= MAP_MID;
      end else if (below) begin
        upper_r <= 1'b0;
        div_r   <= div_lo;
        rem_r   <= d_lo;
        quo_r   <= '0;
      end else begin
        upper_r <= 1'b1;
        div_r   <= div_hi;
        rem_r   <= num_hi[NUM_BITS-1:DIV_STEPS];
        quo_r   <= num_hi[DIV_STEPS-1:0];
      end
    end
    if (state_r == ST_DIV) begin
      step_r <= step_r + 1'b1;
      rem_r  <= ge ? rem_diff[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
      quo_r  <= quo_nxt;
      if (step_r == STEP_BITS'(DIV_STEPS - 1)) begin
        map_r <= {upper_r, quo_nxt};
      end
    end
    if (res_load) begin
      res_r.filtered_value <= cur_r;
      res_r.mapped_value   <= map_r;
      res_r.lowest_seen    <= min_r;
      res_r.highest_seen   <= max_r;
      res_r.tap_value      <= tap_r;
      res_r.tap_due        <= due_r;
    end
  end

  // the partial remainder stays below the divisor throughout the division
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // only an update may raise the tap flag
  a_due_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && due_r) |-> (cmd_r.kind == OP_UPDATE))
    else $error("tap flag raised by a non-update word");

  // a new word is taken only after the previous result has been stored
  a_pop_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r == ST_IDLE) && res_valid_r)
    else $error("result register not loaded on leaving done");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_EXEC))
    else $error("popped word not executed");

endmodule

@@ src/fader_smoothing_and_pitch_map_unit.sv @@
// Top level: configuration registers, front end queue and back end execution unit.
// Flow: an accepted word runs through back end states idle, execute, setup and done (dead
// zone or detent), plus the divide state on a sloped segment; done waits while the result
// register is full. No new word is taken until the result is stored, also during the 13-step
// restoring divider; the two-entry queue lets input words arrive while the back end works.
// Reset: synchronous, active low; empties the queue and result register and loads
// the register and filter state values at once; no clearing pass.
module fader_smoothing_and_pitch_map_unit import fspm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input word channel
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [1:0]                in_operation,
  input  logic [SAMPLE_BITS-1:0]    in_reading,
  // result word channel
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [SAMPLE_BITS-1:0]    out_filtered_value,
  output logic [MAP_BITS-1:0]       out_mapped_value,
  output logic [SAMPLE_BITS-1:0]    out_lowest_seen,
  output logic [SAMPLE_BITS-1:0]    out_highest_seen,
  output logic [SAMPLE_BITS-1:0]    out_tap_value,
  output logic                      out_tap_due,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic res_valid;
  res_t res;

  // Registers take a write in any cycle; software must write only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.snap_threshold  <= SNAP_RST;
      cfg_r.smoothing_shift <= SHIFT_RST;
      cfg_r.low_limit       <= LOW_RST;
      cfg_r.high_limit      <= HIGH_RST;
      cfg_r.detent_point    <= DETENT_RST;
      cfg_r.detent_window   <= WINDOW_RST;
      cfg_r.tap_interval    <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      // truncate the data word to the width of the addressed register;
      // drop writes to the spare index
      unique case (cfg_idx_t'(cfg_index))
        CFG_SNAP:     cfg_r.snap_threshold  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_SHIFT:    cfg_r.smoothing_shift <= cfg_data[SHIFT_BITS-1:0];
        CFG_LOW:      cfg_r.low_limit       <= cfg_data[SAMPLE_BITS-1:0];
        CFG_HIGH:     cfg_r.high_limit      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DETENT:   cfg_r.detent_point    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_WINDOW:   cfg_r.detent_window   <= cfg_data[WINDOW_BITS-1:0];
        CFG_INTERVAL: cfg_r.tap_interval    <= cfg_data[COUNT_BITS-1:0];
        CFG_SPARE:    ;
        default:      ;
      endcase
    end
  end

  // Front end: accept and classify words, hold them in a two-entry queue.
  fspm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_reading   (in_reading),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  // Back end: apply the word to the filter state, map, and hold the result word.
  fspm_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty          = !res_valid;
  assign out_filtered_value = res.filtered_value;
  assign out_mapped_value   = res.mapped_value;
  assign out_lowest_seen    = res.lowest_seen;
  assign out_highest_seen   = res.highest_seen;
  assign out_tap_value      = res.tap_value;
  assign out_tap_due        = res.tap_due;

endmodule
